@@ rtl/core/range_add_range_sum_tree_assert.svh @@
// Assertion macros for the range add / range sum tree checker.
`ifndef RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
`define RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH

// Check that holds in the cycle after the antecedent.
`define RARS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rars assertion failed");

// Check that holds in the same cycle as the antecedent.
`define RARS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rars assertion failed");

`endif

@@ rtl/core/rars_pkg.sv @@
// Shared types and constants of the range add / range sum tree.
package rars_pkg;

	localparam int DW = 64;
	localparam int FW = 11;

	localparam logic [FW-1:0] CNT_RST = 11'd1024;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_UNDO = 2'd1;
	localparam logic [1:0] OP_SUM  = 2'd2;
	localparam logic [1:0] OP_LOAD = 2'd3;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLR_INIT,
		CMD_CLR_STEP,
		CMD_LATCH,
		CMD_HIST_RD,
		CMD_HIST_LD,
		CMD_CLIP,
		CMD_Q_INIT_LO,
		CMD_Q_INIT_HI,
		CMD_Q_RD,
		CMD_Q_ACC,
		CMD_Q_MUL,
		CMD_Q_FIN_LO,
		CMD_Q_FIN_HI,
		CMD_U_INIT_LO,
		CMD_U_INIT_HI,
		CMD_U_MUL,
		CMD_U_RD,
		CMD_U_WR,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       walk_end;
		logic       upd_end;
		logic       range_ok;
		logic [1:0] op;
	} status_t;

endpackage

@@ rtl/core/rars_ctrl.sv @@
// Sequencer of the range add / range sum tree: issues datapath commands per request.
module rars_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output rars_pkg::cmd_t   cmd,
	input  rars_pkg::status_t status
);

	typedef enum logic [4:0] {
		S_CLR_INIT,
		S_CLR,
		S_IDLE,
		S_HRD,
		S_HLD,
		S_CLIP,
		S_DISP,
		S_QI_LO,
		S_QI_HI,
		S_QRD,
		S_QACC,
		S_QMUL,
		S_QFIN,
		S_UI_LO,
		S_UI_HI,
		S_UMUL,
		S_URD,
		S_UWR,
		S_OUT
	} state_t;

	state_t state_q;
	logic   hi_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		case (state_q)
			S_CLR_INIT: cmd = rars_pkg::CMD_CLR_INIT;
			S_CLR:      cmd = rars_pkg::CMD_CLR_STEP;
			S_IDLE:     cmd = in_valid ? rars_pkg::CMD_LATCH : rars_pkg::CMD_NONE;
			S_HRD:      cmd = rars_pkg::CMD_HIST_RD;
			S_HLD:      cmd = rars_pkg::CMD_HIST_LD;
			S_CLIP:     cmd = rars_pkg::CMD_CLIP;
			S_QI_LO:    cmd = rars_pkg::CMD_Q_INIT_LO;
			S_QI_HI:    cmd = rars_pkg::CMD_Q_INIT_HI;
			S_QRD:      cmd = status.walk_end ? rars_pkg::CMD_NONE : rars_pkg::CMD_Q_RD;
			S_QACC:     cmd = rars_pkg::CMD_Q_ACC;
			S_QMUL:     cmd = rars_pkg::CMD_Q_MUL;
			S_QFIN:     cmd = hi_q ? rars_pkg::CMD_Q_FIN_HI : rars_pkg::CMD_Q_FIN_LO;
			S_UI_LO:    cmd = rars_pkg::CMD_U_INIT_LO;
			S_UI_HI:    cmd = rars_pkg::CMD_U_INIT_HI;
			S_UMUL:     cmd = rars_pkg::CMD_U_MUL;
			S_URD:      cmd = status.upd_end ? rars_pkg::CMD_NONE : rars_pkg::CMD_U_RD;
			S_UWR:      cmd = rars_pkg::CMD_U_WR;
			S_OUT:      cmd = out_free ? rars_pkg::CMD_OUT : rars_pkg::CMD_NONE;
			default:    cmd = rars_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR_INIT;
			hi_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR_INIT: state_q <= S_CLR;
				S_CLR: begin
					if (status.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_HRD;
					end
				end
				S_HRD: state_q <= (status.op == rars_pkg::OP_UNDO) ? S_HLD : S_CLIP;
				S_HLD: state_q <= S_CLIP;
				S_CLIP: state_q <= S_DISP;
				S_DISP: begin
					if (!status.range_ok) begin
						state_q <= (status.op == rars_pkg::OP_SUM) ? S_OUT : S_IDLE;
					end else if (status.op == rars_pkg::OP_ADD ||
							status.op == rars_pkg::OP_UNDO) begin
						state_q <= S_UI_LO;
					end else begin
						state_q <= S_QI_LO;
					end
				end
				S_QI_LO: begin
					hi_q    <= 1'b0;
					state_q <= S_QRD;
				end
				S_QI_HI: begin
					hi_q    <= 1'b1;
					state_q <= S_QRD;
				end
				S_QRD: state_q <= status.walk_end ? S_QMUL : S_QACC;
				S_QACC: state_q <= S_QRD;
				S_QMUL: state_q <= S_QFIN;
				S_QFIN: begin
					if (!hi_q) begin
						state_q <= S_QI_HI;
					end else if (status.op == rars_pkg::OP_SUM) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_UI_LO;
					end
				end
				S_UI_LO: begin
					hi_q    <= 1'b0;
					state_q <= S_UMUL;
				end
				S_UI_HI: begin
					hi_q    <= 1'b1;
					state_q <= S_UMUL;
				end
				S_UMUL: state_q <= S_URD;
				S_URD: begin
					if (!status.upd_end) begin
						state_q <= S_UWR;
					end else begin
						state_q <= hi_q ? S_IDLE : S_UI_HI;
					end
				end
				S_UWR: state_q <= S_URD;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/rars_dp.sv @@
// Datapath: two Fenwick tables for range add / range sum, history store, clipping.
module rars_dp #(
	parameter int ARRAY_SIZE    = 1024,
	parameter int HISTORY_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rars_pkg::FW-1:0]     cfg_wr_data,
	input  logic [1:0]                  in_op,
	input  logic [rars_pkg::FW-1:0]     in_left,
	input  logic [rars_pkg::FW-1:0]     in_right,
	input  logic [rars_pkg::DW-1:0]     in_value,
	input  logic [rars_pkg::FW-1:0]     in_ref,
	input  rars_pkg::cmd_t              cmd,
	output rars_pkg::status_t           status,
	output logic [rars_pkg::DW-1:0]     sum_out
);

	localparam int DW  = rars_pkg::DW;
	localparam int FW  = rars_pkg::FW;
	localparam int IW  = $clog2(2 * ARRAY_SIZE + 1);
	localparam int AW  = $clog2(ARRAY_SIZE + 1);
	localparam int CW  = (IW > FW) ? IW : FW;
	localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int NW  = $clog2(HISTORY_DEPTH + 1);
	localparam int RW  = (NW > FW) ? NW : FW;
	localparam int HEW = 2 * FW + DW;

	logic [DW-1:0]  tab1 [0:ARRAY_SIZE];
	logic [DW-1:0]  tab2 [0:ARRAY_SIZE];
	logic [HEW-1:0] hist [0:HISTORY_DEPTH-1];

	logic [FW-1:0]  cnt_q;
	logic [NW-1:0]  item_q;
	logic [1:0]     op_q;
	logic [FW-1:0]  l_q, r_q, ref_q;
	logic [DW-1:0]  val_q;
	logic [HEW-1:0] hist_rd_q;
	logic [IW-1:0]  a_q, b_q, idx_q, pos_q;
	logic           ok_q;
	logic [DW-1:0]  acc1_q, acc2_q, d1_q, d2_q, m_q, pa_q, diff_q, delta_q;
	logic [DW-1:0]  rd1_q, rd2_q, sum_q;

	logic           rec_ok, ref_hit, hist_we, mem_we, load_ok;
	logic [RW-1:0]  ref_m1;
	logic [HEW-1:0] hist_wd;
	logic [FW-1:0]  hl, hr;
	logic [DW-1:0]  hamt, dl;
	logic [CW-1:0]  cnt_eff, lo_c, hi_c;
	logic [IW-1:0]  lowbit;
	logic [AW-1:0]  addr;

	assign rec_ok  = item_q < NW'(HISTORY_DEPTH);
	assign ref_m1  = RW'(ref_q) - RW'(1);
	assign ref_hit = (ref_q != '0) && (ref_m1 < RW'(item_q));
	assign hl      = hist_rd_q[HEW-1 -: FW];
	assign hr      = hist_rd_q[DW +: FW];
	assign hamt    = hist_rd_q[DW-1:0];

	assign cnt_eff = (CW'(cnt_q) < CW'(ARRAY_SIZE)) ? CW'(cnt_q) : CW'(ARRAY_SIZE);
	assign lo_c    = (l_q == '0) ? CW'(1) : CW'(l_q);
	assign hi_c    = (CW'(r_q) > cnt_eff) ? cnt_eff : CW'(r_q);
	assign load_ok = (l_q != '0) && (CW'(l_q) <= cnt_eff);

	assign lowbit  = idx_q & (~idx_q + IW'(1));
	assign addr    = idx_q[AW-1:0];
	assign dl      = (op_q == rars_pkg::OP_LOAD) ? (val_q - diff_q) : val_q;

	always_comb begin
		hist_we = 1'b0;
		hist_wd = '0;
		if (cmd == rars_pkg::CMD_LATCH) begin
			hist_we = rec_ok && (in_op == rars_pkg::OP_ADD || in_op == rars_pkg::OP_SUM);
			hist_wd = (in_op == rars_pkg::OP_ADD) ? {in_left, in_right, in_value} : '0;
		end else if (cmd == rars_pkg::CMD_HIST_LD) begin
			hist_we = rec_ok;
			hist_wd = ref_hit ? {hl, hr, DW'(0) - hamt} : '0;
		end
	end

	assign mem_we = (cmd == rars_pkg::CMD_CLR_STEP) || (cmd == rars_pkg::CMD_U_WR);

	assign status.clr_last = (idx_q == IW'(ARRAY_SIZE));
	assign status.walk_end = (idx_q == '0);
	assign status.upd_end  = (idx_q > IW'(ARRAY_SIZE));
	assign status.range_ok = ok_q;
	assign status.op       = op_q;
	assign sum_out         = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= rars_pkg::CNT_RST;
			item_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cnt_q <= cfg_wr_data;
			end
			if (hist_we) begin
				item_q <= item_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tab1[addr] <= (cmd == rars_pkg::CMD_CLR_STEP) ? '0 : rd1_q + d1_q;
			tab2[addr] <= (cmd == rars_pkg::CMD_CLR_STEP) ? '0 : rd2_q + d2_q;
		end
		if (cmd == rars_pkg::CMD_Q_RD || cmd == rars_pkg::CMD_U_RD) begin
			rd1_q <= tab1[addr];
			rd2_q <= tab2[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist[item_q[HW-1:0]] <= hist_wd;
		end
		if (cmd == rars_pkg::CMD_HIST_RD) begin
			hist_rd_q <= hist[ref_m1[HW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			rars_pkg::CMD_CLR_INIT: idx_q <= IW'(1);
			rars_pkg::CMD_CLR_STEP: idx_q <= idx_q + IW'(1);
			rars_pkg::CMD_LATCH: begin
				op_q  <= in_op;
				l_q   <= in_left;
				r_q   <= in_right;
				val_q <= in_value;
				ref_q <= in_ref;
			end
			rars_pkg::CMD_HIST_LD: begin
				l_q   <= ref_hit ? hl : '0;
				r_q   <= ref_hit ? hr : '0;
				val_q <= ref_hit ? DW'(0) - hamt : '0;
			end
			rars_pkg::CMD_CLIP: begin
				diff_q <= '0;
				if (op_q == rars_pkg::OP_LOAD) begin
					a_q  <= IW'(l_q);
					b_q  <= IW'(l_q);
					ok_q <= load_ok;
				end else begin
					a_q  <= IW'(lo_c);
					b_q  <= IW'(hi_c);
					ok_q <= (lo_c <= hi_c);
				end
			end
			rars_pkg::CMD_Q_INIT_LO: begin
				idx_q  <= a_q - IW'(1);
				pos_q  <= a_q - IW'(1);
				acc1_q <= '0;
				acc2_q <= '0;
			end
			rars_pkg::CMD_Q_INIT_HI: begin
				idx_q  <= b_q;
				pos_q  <= b_q;
				acc1_q <= '0;
				acc2_q <= '0;
			end
			rars_pkg::CMD_Q_ACC: begin
				acc1_q <= acc1_q + rd1_q;
				acc2_q <= acc2_q + rd2_q;
				idx_q  <= idx_q - lowbit;
			end
			rars_pkg::CMD_Q_MUL: m_q <= DW'(acc1_q * pos_q);
			rars_pkg::CMD_Q_FIN_LO: pa_q <= m_q - acc2_q;
			rars_pkg::CMD_Q_FIN_HI: diff_q <= m_q - acc2_q - pa_q;
			rars_pkg::CMD_U_INIT_LO: begin
				idx_q   <= a_q;
				d1_q    <= dl;
				delta_q <= dl;
			end
			rars_pkg::CMD_U_INIT_HI: begin
				idx_q <= b_q + IW'(1);
				d1_q  <= DW'(0) - delta_q;
			end
			rars_pkg::CMD_U_MUL: d2_q <= DW'(d1_q * (idx_q - IW'(1)));
			rars_pkg::CMD_U_WR: idx_q <= idx_q + lowbit;
			rars_pkg::CMD_OUT: sum_q <= diff_q;
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/range_add_range_sum_tree.sv @@
// Top level of the range add / range sum tree.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  config   | cfg_wr_en            | cfg_wr_data (element_count)
//  request  | in_valid / in_stall  | op, left, right, value, ref_index
//  result   | out_valid / out_stall| range_sum (sum requests only)
//
// After reset a clearing pass writes ARRAY_SIZE table entries, one per cycle;
// requests stall meanwhile. One request at a time: latch, history read (and load for
// an undo), clipping, dispatch, then for a valid range the walks: a prefix walk visits
// up to log2(ARRAY_SIZE) nodes, an update walk up to log2(ARRAY_SIZE)+1. An add
// or undo walks two updates, a sum two prefixes, a load two prefixes and two updates.
// A finished sum waits in the output register; a later sum waits behind it.
module range_add_range_sum_tree #(
	parameter int ARRAY_SIZE    = 1024,
	parameter int HISTORY_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [10:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [10:0]        left,
	input  logic [10:0]        right,
	input  logic signed [63:0] value,
	input  logic [10:0]        ref_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] range_sum
);

	rars_pkg::cmd_t    cmd;
	rars_pkg::status_t status;
	logic [rars_pkg::DW-1:0] sum_out;

	rars_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	rars_dp #(
		.ARRAY_SIZE    (ARRAY_SIZE),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_op       (op),
		.in_left     (left),
		.in_right    (right),
		.in_value    (value),
		.in_ref      (ref_index),
		.cmd         (cmd),
		.status      (status),
		.sum_out     (sum_out)
	);

	assign range_sum = sum_out;

endmodule

@@ rtl/core/rars_chk.sv @@
// Port-level checker for the range add / range sum tree, bound to the top level.
`include "range_add_range_sum_tree_assert.svh"

module rars_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] range_sum
);

	`RARS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`RARS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(range_sum))
	`RARS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	`RARS_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind range_add_range_sum_tree rars_chk u_chk (.*);

@@ tb/sv/tb_range_add_range_sum_tree.sv @@
// Testbench for range_add_range_sum_tree: directed and random requests checked against an array model.
`timescale 1ns / 100ps

module tb_range_add_range_sum_tree;

	typedef struct {
		logic [1:0]  op;
		logic [10:0] lo_idx;
		logic [10:0] hi_idx;
		logic [63:0] amount;
		logic [10:0] undo_idx;
	} req_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic [10:0] left;
	logic [10:0] right;
	logic signed [63:0] value;
	logic [10:0] ref_index;
	logic out_valid;
	logic out_stall;
	logic signed [63:0] range_sum;

	req_t pending_reqs[$];
	logic [63:0] expected_sums[$];
	int mismatches;
	int send_gap;
	int stall_gap;
	bit busy_mode;

	logic [63:0] elem[1:1024];
	logic [10:0] hist_lo[0:1023];
	logic [10:0] hist_hi[0:1023];
	logic [63:0] hist_amt[0:1023];
	int seq_num;
	int elem_count;

	range_add_range_sum_tree u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .left(left), .right(right),
		.value(value), .ref_index(ref_index), .out_valid(out_valid),
		.out_stall(out_stall), .range_sum(range_sum)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int live_count();
		return elem_count < 1024 ? elem_count : 1024;
	endfunction

	function automatic void add_range(int l, int r, logic [63:0] amt);
		int a;
		int b;
		a = l < 1 ? 1 : l;
		b = r > live_count() ? live_count() : r;
		for (int i = a; i <= b; i++)
			elem[i] += amt;
	endfunction

	function automatic void log_item(logic [10:0] l, logic [10:0] r, logic [63:0] amt);
		if (seq_num < 1024) begin
			hist_lo[seq_num] = l;
			hist_hi[seq_num] = r;
			hist_amt[seq_num] = amt;
			seq_num++;
		end
	endfunction

	function automatic void predict_request(req_t q);
		logic [63:0] s;
		logic [10:0] hl;
		logic [10:0] hr;
		logic [63:0] ha;
		int a;
		int b;
		case (q.op)
			rars_pkg::OP_ADD: begin
				add_range(q.lo_idx, q.hi_idx, q.amount);
				log_item(q.lo_idx, q.hi_idx, q.amount);
			end
			rars_pkg::OP_UNDO: begin
				hl = '0;
				hr = '0;
				ha = '0;
				if (q.undo_idx >= 1 && q.undo_idx <= 1024) begin
					hl = hist_lo[q.undo_idx - 1];
					hr = hist_hi[q.undo_idx - 1];
					ha = 64'd0 - hist_amt[q.undo_idx - 1];
				end
				add_range(hl, hr, ha);
				log_item(hl, hr, ha);
			end
			rars_pkg::OP_SUM: begin
				s = '0;
				a = q.lo_idx < 1 ? 1 : q.lo_idx;
				b = q.hi_idx > live_count() ? live_count() : q.hi_idx;
				for (int i = a; i <= b; i++)
					s += elem[i];
				expected_sums.push_back(s);
				log_item('0, '0, '0);
			end
			default: begin
				if (q.lo_idx >= 1 && q.lo_idx <= live_count())
					elem[q.lo_idx] = q.amount;
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int k;
		if (!busy_mode)
			return 0;
		k = $urandom_range(0, 19);
		if (k < 11)
			return 0;
		if (k < 18)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// driver
	always @(posedge clk) begin
		req_t q;
		if (in_valid && !in_stall) begin
			q.op = op;
			q.lo_idx = left;
			q.hi_idx = right;
			q.amount = value;
			q.undo_idx = ref_index;
			predict_request(q);
		end
		if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				q = pending_reqs.pop_front();
				op <= q.op;
				left <= q.lo_idx;
				right <= q.hi_idx;
				value <= q.amount;
				ref_index <= q.undo_idx;
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [63:0] e;
		if (out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected sum %0d", range_sum));
			end else begin
				e = expected_sums.pop_front();
				if (range_sum !== e)
					report_mismatch($sformatf("range_sum got %0d want %0d",
						range_sum, $signed(e)));
			end
		end
		if (stall_gap > 0) begin
			stall_gap <= stall_gap - 1;
			out_stall <= 1'b1;
		end else begin
			stall_gap <= pick_gap();
			out_stall <= 1'b0;
		end
	end

	task automatic push_req(logic [1:0] o, logic [10:0] l, logic [10:0] r,
			logic [63:0] v, logic [10:0] u);
		req_t q;
		q.op = o;
		q.lo_idx = l;
		q.hi_idx = r;
		q.amount = v;
		q.undo_idx = u;
		pending_reqs.push_back(q);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() > 0 || in_valid || in_stall ||
			expected_sums.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_count(logic [10:0] c);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		elem_count = c;
	endtask

	function automatic logic [63:0] rand_amount();
		case ($urandom_range(0, 3))
			0: return {{32{1'b0}}, 32'($urandom_range(0, 1000))};
			1: return 64'd0 - 64'($urandom_range(0, 1000));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_random(int n);
		int c;
		int l;
		int r;
		logic [1:0] o;
		c = live_count() < 1 ? 1 : live_count();
		for (int i = 0; i < n; i++) begin
			o = 2'($urandom_range(0, 3));
			l = $urandom_range(1, c);
			r = $urandom_range(l, c);
			if ($urandom_range(0, 9) == 0) begin
				l = $urandom_range(0, 2047);
				r = $urandom_range(0, 2047);
			end
			if ($urandom_range(0, 9) == 0)
				push_req(o, l, r, rand_amount(), 11'($urandom_range(0, 2047)));
			else
				push_req(o, l, r, rand_amount(), 11'($urandom_range(1, seq_num + 1)));
		end
	endtask

	initial begin
		logic [10:0] counts[6];
		mismatches = 0;
		send_gap = 0;
		stall_gap = 0;
		busy_mode = 1'b1;
		seq_num = 0;
		elem_count = 1024;
		for (int i = 1; i <= 1024; i++)
			elem[i] = '0;
		for (int i = 0; i < 1024; i++) begin
			hist_lo[i] = '0;
			hist_hi[i] = '0;
			hist_amt[i] = '0;
		end
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = rars_pkg::OP_ADD;
		left = '0;
		right = '0;
		value = '0;
		ref_index = '0;
		out_stall = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_count(rars_pkg::CNT_RST);
		push_req(rars_pkg::OP_LOAD, 11'd1, 11'd0, 64'h7fff_ffff_ffff_ffff, 11'd0);
		push_req(rars_pkg::OP_LOAD, 11'd1024, 11'd0, 64'h8000_0000_0000_0000, 11'd0);
		push_req(rars_pkg::OP_LOAD, 11'd0, 11'd0, 64'd55, 11'd0);
		push_req(rars_pkg::OP_LOAD, 11'd2047, 11'd0, 64'd66, 11'd0);
		push_req(rars_pkg::OP_LOAD, 11'd512, 11'd0, 64'hffff_ffff_ffff_ffff, 11'd0);
		push_req(rars_pkg::OP_SUM, 11'd1, 11'd1024, '0, 11'd0);
		push_req(rars_pkg::OP_ADD, 11'd1, 11'd1024, 64'd3, 11'd0);
		push_req(rars_pkg::OP_ADD, 11'd0, 11'd2047, 64'h8000_0000_0000_0000, 11'd0);
		push_req(rars_pkg::OP_ADD, 11'd700, 11'd300, 64'd9, 11'd0);
		push_req(rars_pkg::OP_SUM, 11'd0, 11'd2047, '0, 11'd0);
		push_req(rars_pkg::OP_SUM, 11'd1024, 11'd1024, '0, 11'd0);
		push_req(rars_pkg::OP_SUM, 11'd900, 11'd5, '0, 11'd0);
		push_req(rars_pkg::OP_UNDO, 11'd0, 11'd0, '0, 11'd1);
		push_req(rars_pkg::OP_UNDO, 11'd0, 11'd0, '0, 11'd7);
		push_req(rars_pkg::OP_UNDO, 11'd0, 11'd0, '0, 11'd0);
		push_req(rars_pkg::OP_UNDO, 11'd0, 11'd0, '0, 11'd2047);
		push_req(rars_pkg::OP_UNDO, 11'd0, 11'd0, '0, 11'd10);
		push_req(rars_pkg::OP_UNDO, 11'd0, 11'd0, '0, 11'd500);
		push_req(rars_pkg::OP_SUM, 11'd1, 11'd1024, '0, 11'd0);
		push_req(rars_pkg::OP_LOAD, 11'd1, 11'd0, 64'd5, 11'd0);
		push_req(rars_pkg::OP_SUM, 11'd1, 11'd2, '0, 11'd0);
		wait_drained();

		counts = '{11'd1, 11'd37, 11'd2047, 11'd0, 11'd1024, 11'd600};
		foreach (counts[k]) begin
			write_count(counts[k]);
			busy_mode = (k != 4);
			push_random(170);
			wait_drained();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rars_pkg.sv
rtl/core/rars_ctrl.sv
rtl/core/rars_dp.sv
rtl/core/range_add_range_sum_tree.sv
rtl/core/rars_chk.sv
tb/sv/tb_range_add_range_sum_tree.sv
